FILE: hdl/vxs_pkg.sv
// ---------------------------------------------------------------------------
// vxs_pkg
// Shared types, widths and codes for the voxel excess significance block.
// ---------------------------------------------------------------------------
package vxs_pkg;

   localparam int GRID_BINS  = 32;
   localparam int COUNT_BITS = 24;

   localparam int BIN_W      = 5;
   localparam int SCALE_W    = 20;
   localparam int SIGMA_W    = 4;
   localparam int DIFF_W     = 40;
   localparam int SIG_W      = 32;
   localparam int SUM_W      = 40;
   localparam int CLASS_W    = 2;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SCALE_W;

   localparam logic [SCALE_W-1:0] TARGET_SCALE_RST     = SCALE_W'(10000);
   localparam logic [SCALE_W-1:0] BACKGROUND_SCALE_RST = SCALE_W'(10000);
   localparam logic [SIGMA_W-1:0] SIGMA_RST            = SIGMA_W'(4);

   // arithmetic widths
   localparam int PROD_W  = COUNT_BITS + SCALE_W;       // background * scale
   localparam int SB_W    = PROD_W + 8;                 // scaled background, Q.8
   localparam int ROOT_W  = (COUNT_BITS + 17) / 2;      // sqrt of count in Q.8
   localparam int RAD_W   = 2 * ROOT_W;
   localparam int ERR_W   = ROOT_W + SCALE_W;
   localparam int THR_W   = ERR_W + SIGMA_W;
   localparam int D_W     = SB_W + 2;                   // signed difference
   localparam int DIV_NW  = SB_W;
   localparam int DIV_DW  = ERR_W;

   localparam int CELLS   = GRID_BINS * GRID_BINS;
   localparam int CELL_AW = $clog2(CELLS);

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_SCALE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKGROUND_SCALE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGMA_THRESHOLD  = 2'd2;

   localparam logic [CLASS_W-1:0] CLASS_NONE    = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_EXCESS  = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_DEFICIT = 2'd2;

   typedef struct packed {
      logic                  req_type;
      logic [BIN_W-1:0]      bin_x;
      logic [BIN_W-1:0]      bin_y;
      logic [BIN_W-1:0]      bin_z;
      logic [COUNT_BITS-1:0] target_count;
      logic [COUNT_BITS-1:0] background_count;
   } req_item_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] difference;
      logic [CLASS_W-1:0]       class_code;
      logic [SIG_W-1:0]         significance;
      logic [SUM_W-1:0]         sum_xy;
      logic [SUM_W-1:0]         sum_xz;
      logic [SUM_W-1:0]         sum_yz;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PREP,
      ST_SB_GO,
      ST_SB_WAIT,
      ST_ERR_MUL,
      ST_ERR_GO,
      ST_ERR_WAIT,
      ST_THR,
      ST_CMP,
      ST_SIG_GO,
      ST_SIG_WAIT,
      ST_MEM_RD,
      ST_MEM_WAIT,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic prep;
      logic sb_start;
      logic latch_sb;
      logic err_mul;
      logic err_start;
      logic latch_err;
      logic thr;
      logic cmp;
      logic sig_start;
      logic latch_sig;
      logic mem_wr;
      logic latch_sums;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic new_is_read;
      logic is_read;
      logic div_busy;
      logic sqrt_busy;
      logic excess;
      logic in_grid;
   } ctrl_status_type;

endpackage

FILE: hdl/vxs_divider.sv
// ---------------------------------------------------------------------------
// vxs_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module vxs_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [vxs_pkg::DIV_NW-1:0]   num,
   input  logic [vxs_pkg::DIV_DW-1:0]   den,
   output logic                         busy,
   output logic [vxs_pkg::DIV_NW-1:0]   quot
);
   import vxs_pkg::*;

   localparam int CNT_W = $clog2(DIV_NW + 1);

   logic [DIV_NW-1:0] quot_ff, quot_in;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_DW-1:0] den_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [DIV_DW:0]   shifted;
   logic [DIV_DW:0]   trial;

   always_comb begin
      shifted = {rem_ff, quot_ff[DIV_NW-1]};
      trial   = shifted - {1'b0, den_ff};
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quot_in = num;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // no borrow: divisor fits, take the bit
         if (!trial[DIV_DW]) begin
            rem_in  = trial[DIV_DW-1:0];
            quot_in = {quot_ff[DIV_NW-2:0], 1'b1};
         end else begin
            rem_in  = shifted[DIV_DW-1:0];
            quot_in = {quot_ff[DIV_NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_NW - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      if (start) begin
         den_ff <= den;
      end
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

FILE: hdl/vxs_sqrt.sv
// ---------------------------------------------------------------------------
// vxs_sqrt
// Bit-serial integer square root, one root bit per cycle.
// ---------------------------------------------------------------------------
module vxs_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [vxs_pkg::RAD_W-1:0]  radicand,
   output logic                       busy,
   output logic [vxs_pkg::ROOT_W-1:0] root
);
   import vxs_pkg::*;

   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [ROOT_W:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [ROOT_W+2:0] shifted;
   logic [ROOT_W+2:0] trial;
   logic [ROOT_W+2:0] diff;

   always_comb begin
      shifted = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      diff    = shifted - trial;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = diff[ROOT_W:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[ROOT_W:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

FILE: hdl/vxs_datapath.sv
// ---------------------------------------------------------------------------
// vxs_datapath
// Config registers, scaling arithmetic, projection stores, result register.
// ---------------------------------------------------------------------------
module vxs_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  vxs_pkg::ctrl_cmd_type           cmd,
   output vxs_pkg::ctrl_status_type        status,
   input  vxs_pkg::req_item_type           req_item,
   input  logic                            csr_write,
   input  logic [vxs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vxs_pkg::CSR_DATA_W-1:0]  csr_data,
   output vxs_pkg::rsp_item_type           rsp_item
);
   import vxs_pkg::*;

   localparam logic signed [D_W-1:0] DIFF_MAX_D =
      $signed({{(D_W-DIFF_W+1){1'b0}}, {(DIFF_W-1){1'b1}}});
   localparam logic signed [D_W-1:0] DIFF_MIN_D =
      $signed({{(D_W-DIFF_W+1){1'b1}}, {(DIFF_W-1){1'b0}}});

   logic [SCALE_W-1:0] ts_ff, bs_ff;
   logic [SIGMA_W-1:0] sigma_ff;

   req_item_type       item_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [SB_W-1:0]    sb_ff;
   logic [ERR_W-1:0]   err_ff;
   logic [THR_W-1:0]   thr_ff;
   logic signed [D_W-1:0] d_ff;
   logic [CLASS_W-1:0] cls_ff;
   logic [SIG_W-1:0]   sig_ff;
   logic [SUM_W-1:0]   sxy_ff, sxz_ff, syz_ff;
   rsp_item_type       out_ff;
   logic [CELL_AW-1:0] clr_ff;

   logic [SCALE_W-1:0] den_eff;
   logic               div_start;
   logic [DIV_NW-1:0]  div_num;
   logic [DIV_DW-1:0]  div_den;
   logic               div_busy;
   logic [DIV_NW-1:0]  quot;
   logic               sqrt_busy;
   logic [ROOT_W-1:0]  root;

   logic signed [D_W-1:0] thr_s;
   logic               excess, deficit, in_grid;
   logic signed [DIFF_W-1:0] diff_sat;

   logic [CELL_AW-1:0] xy_addr, xz_addr, yz_addr;
   logic [CELL_AW-1:0] xy_a, xz_a, yz_a;
   logic [SUM_W-1:0]   xy_mem [CELLS];
   logic [SUM_W-1:0]   xz_mem [CELLS];
   logic [SUM_W-1:0]   yz_mem [CELLS];
   logic [SUM_W-1:0]   xy_rd_ff, xz_rd_ff, yz_rd_ff;
   logic [SUM_W-1:0]   xy_wd, xz_wd, yz_wd;
   logic               mem_we;
   rsp_item_type       out_in;

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [SIG_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + (SUM_W+1)'(b);
      return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
   endfunction

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         ts_ff    <= TARGET_SCALE_RST;
         bs_ff    <= BACKGROUND_SCALE_RST;
         sigma_ff <= SIGMA_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TARGET_SCALE:     ts_ff    <= csr_data;
            CSR_BACKGROUND_SCALE: bs_ff    <= csr_data;
            CSR_SIGMA_THRESHOLD:  sigma_ff <= csr_data[SIGMA_W-1:0];
            default: ;
         endcase
      end
   end

   assign den_eff = (bs_ff == '0) ? SCALE_W'(1) : bs_ff;

   // shared divider operands
   always_comb begin
      div_start = cmd.sb_start | cmd.err_start | cmd.sig_start;
      div_num   = {prod_ff, 8'h00};
      div_den   = DIV_DW'(den_eff);
      if (cmd.err_start) begin
         div_num = DIV_NW'(prod_ff);
      end else if (cmd.sig_start) begin
         div_num = DIV_NW'({d_ff[COUNT_BITS+7:0], 8'h00});
         div_den = err_ff;
      end
   end

   vxs_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quot  (quot)
   );

   vxs_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sb_start),
      .radicand (RAD_W'({item_ff.background_count, 16'h0000})),
      .busy     (sqrt_busy),
      .root     (root)
   );

   assign thr_s   = $signed(D_W'(thr_ff));
   assign excess  = (d_ff > thr_s) && (sb_ff != '0);
   assign deficit = (-d_ff) > thr_s;
   assign in_grid = (int'(item_ff.bin_x) < GRID_BINS) && (int'(item_ff.bin_y) < GRID_BINS)
                    && (int'(item_ff.bin_z) < GRID_BINS);

   always_comb begin
      if (d_ff > DIFF_MAX_D) begin
         diff_sat = DIFF_MAX_D[DIFF_W-1:0];
      end else if (d_ff < DIFF_MIN_D) begin
         diff_sat = DIFF_MIN_D[DIFF_W-1:0];
      end else begin
         diff_sat = d_ff[DIFF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_item;
      end
      if (cmd.prep) begin
         prod_ff <= PROD_W'(item_ff.background_count * ts_ff);
      end else if (cmd.err_mul) begin
         prod_ff <= PROD_W'(root * ts_ff);
      end
      if (cmd.latch_sb) begin
         sb_ff <= quot;
      end
      if (cmd.latch_err) begin
         err_ff <= quot[ERR_W-1:0];
      end
      if (cmd.thr) begin
         thr_ff <= THR_W'(sigma_ff * err_ff);
         d_ff   <= $signed(D_W'({item_ff.target_count, 8'h00})) - $signed(D_W'(sb_ff));
      end
      if (cmd.cmp) begin
         cls_ff <= excess ? CLASS_EXCESS : (deficit ? CLASS_DEFICIT : CLASS_NONE);
         sig_ff <= '0;
      end else if (cmd.latch_sig) begin
         // zero error divides to all ones, which saturates as wanted
         sig_ff <= (|quot[DIV_NW-1:SIG_W]) ? {SIG_W{1'b1}} : quot[SIG_W-1:0];
      end
      if (cmd.latch_sums) begin
         sxy_ff <= in_grid ? xy_rd_ff : '0;
         sxz_ff <= in_grid ? xz_rd_ff : '0;
         syz_ff <= in_grid ? yz_rd_ff : '0;
      end
      if (cmd.load_out) begin
         out_ff <= out_in;
      end
   end

   always_comb begin
      out_in = '0;
      if (item_ff.req_type) begin
         out_in.sum_xy = sxy_ff;
         out_in.sum_xz = sxz_ff;
         out_in.sum_yz = syz_ff;
      end else begin
         out_in.difference   = diff_sat;
         out_in.class_code   = cls_ff;
         out_in.significance = sig_ff;
      end
   end

   // projection stores
   assign xy_a = CELL_AW'(int'(item_ff.bin_x) * GRID_BINS + int'(item_ff.bin_y));
   assign xz_a = CELL_AW'(int'(item_ff.bin_x) * GRID_BINS + int'(item_ff.bin_z));
   assign yz_a = CELL_AW'(int'(item_ff.bin_y) * GRID_BINS + int'(item_ff.bin_z));

   always_comb begin
      xy_addr = cmd.clear ? clr_ff : xy_a;
      xz_addr = cmd.clear ? clr_ff : xz_a;
      yz_addr = cmd.clear ? clr_ff : yz_a;
      mem_we  = cmd.clear | (cmd.mem_wr & in_grid);
      xy_wd   = cmd.clear ? '0 : sat_add(xy_rd_ff, sig_ff);
      xz_wd   = cmd.clear ? '0 : sat_add(xz_rd_ff, sig_ff);
      yz_wd   = cmd.clear ? '0 : sat_add(yz_rd_ff, sig_ff);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         xy_mem[xy_addr] <= xy_wd;
         xz_mem[xz_addr] <= xz_wd;
         yz_mem[yz_addr] <= yz_wd;
      end
      xy_rd_ff <= xy_mem[xy_addr];
      xz_rd_ff <= xz_mem[xz_addr];
      yz_rd_ff <= yz_mem[yz_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_comb begin
      status             = '0;
      status.clear_done  = (clr_ff == CELL_AW'(CELLS - 1));
      status.new_is_read = req_item.req_type;
      status.is_read     = item_ff.req_type;
      status.div_busy    = div_busy;
      status.sqrt_busy   = sqrt_busy;
      status.excess      = excess;
      status.in_grid     = in_grid;
   end

   assign rsp_item = out_ff;

endmodule

FILE: hdl/vxs_ctrl.sv
// ---------------------------------------------------------------------------
// vxs_ctrl
// Sequencer: clearing pass, arithmetic steps, store update, result handoff.
// ---------------------------------------------------------------------------
module vxs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output vxs_pkg::ctrl_cmd_type    cmd,
   input  vxs_pkg::ctrl_status_type status
);
   import vxs_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;
   logic           accept;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = status.new_is_read ? ST_MEM_RD : ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_SB_GO;
         end
         ST_SB_GO: begin
            cmd.sb_start = 1'b1;
            state_in     = ST_SB_WAIT;
         end
         ST_SB_WAIT: begin
            if (!status.div_busy && !status.sqrt_busy) begin
               cmd.latch_sb = 1'b1;
               state_in     = ST_ERR_MUL;
            end
         end
         ST_ERR_MUL: begin
            cmd.err_mul = 1'b1;
            state_in    = ST_ERR_GO;
         end
         ST_ERR_GO: begin
            cmd.err_start = 1'b1;
            state_in      = ST_ERR_WAIT;
         end
         ST_ERR_WAIT: begin
            if (!status.div_busy) begin
               cmd.latch_err = 1'b1;
               state_in      = ST_THR;
            end
         end
         ST_THR: begin
            cmd.thr  = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = status.excess ? ST_SIG_GO : ST_OUT;
         end
         ST_SIG_GO: begin
            cmd.sig_start = 1'b1;
            state_in      = ST_SIG_WAIT;
         end
         ST_SIG_WAIT: begin
            if (!status.div_busy) begin
               cmd.latch_sig = 1'b1;
               state_in      = status.in_grid ? ST_MEM_RD : ST_OUT;
            end
         end
         ST_MEM_RD: begin
            state_in = ST_MEM_WAIT;
         end
         ST_MEM_WAIT: begin
            if (status.is_read) begin
               cmd.latch_sums = 1'b1;
            end else begin
               cmd.mem_wr = 1'b1;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (slot_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted item did not start work");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_result_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && rsp_valid_ff && rsp_stall |=> state_ff == ST_OUT)
      else $error("finished result left while output slot busy");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !accept)
      else $error("item accepted during store clearing");

endmodule

FILE: hdl/voxel_excess_significance.sv
// ---------------------------------------------------------------------------
// voxel_excess_significance
// Voxel excess test against scaled background, with XY/XZ/YZ projection sums.
// ---------------------------------------------------------------------------
// Use:
//   req channel (req_valid/req_stall/req_item): one voxel or one read request.
//   rsp channel (rsp_valid/rsp_stall/rsp_item): exactly one result per item.
//   csr port: csr_write/csr_index/csr_data, write only, while idle.
// Sequencing (one item in flight at a time):
//   excess voxel: three passes through the single bit-serial divider
//     (scaled background, scaled error, significance); the square root runs
//     during the first pass.
//   other voxel: skips the third pass and the store update.
//   read item: a registered store read.
// Reset: config returns to defaults, then a clearing pass over all CELLS
//   cells (1024) zeroes the three projection stores; no item is taken meanwhile.
// Stall: the result sits in an output register; the next item is accepted
//   while it waits, and its own result is held back until that slot frees.
// ---------------------------------------------------------------------------
module voxel_excess_significance (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  vxs_pkg::req_item_type           req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output vxs_pkg::rsp_item_type           rsp_item,
   input  logic                            csr_write,
   input  logic [vxs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vxs_pkg::CSR_DATA_W-1:0]  csr_data
);
   import vxs_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // sequencer
   vxs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // arithmetic, stores, config and result register
   vxs_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_item  (req_item),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_item  (rsp_item)
   );

endmodule

FILE: verif/tb_voxel_excess_significance.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_voxel_excess_significance
// Self-checking bench: random voxel and read items with idles and stalls,
// predicted results compared as whole items in arrival order, across several
// scale and threshold settings.
// ---------------------------------------------------------------------------
module tb_voxel_excess_significance;
   import vxs_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_TARGET_SCALE;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   voxel_excess_significance dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: configuration and projection stores
   logic [SCALE_W-1:0] tgt_scale;
   logic [SCALE_W-1:0] bkg_scale;
   logic [SIGMA_W-1:0] sigma;
   logic [SUM_W-1:0] xy_sum [CELLS];
   logic [SUM_W-1:0] xz_sum [CELLS];
   logic [SUM_W-1:0] yz_sum [CELLS];

   req_item_type pending_items[$];
   rsp_item_type expected_rsps[$];
   int mismatches = 0;
   int idle_pct = 35;   // 0 gives a stretch with no idling
   int quiet_cycles = 0;

   function automatic logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [SUM_W-1:0] sat40(logic [SUM_W-1:0] a, logic [SIG_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + b;
      return s[SUM_W] ? '1 : s[SUM_W-1:0];
   endfunction

   // compute the result of one item and update the projection stores
   function automatic rsp_item_type voxel_result(req_item_type it);
      rsp_item_type r;
      logic [63:0] den, sb, root, err, sig;
      longint d, thr;
      int cxy, cxz, cyz;
      r = '0;
      cxy = it.bin_x * GRID_BINS + it.bin_y;
      cxz = it.bin_x * GRID_BINS + it.bin_z;
      cyz = it.bin_y * GRID_BINS + it.bin_z;
      if (it.req_type) begin
         r.sum_xy = xy_sum[cxy];
         r.sum_xz = xz_sum[cxz];
         r.sum_yz = yz_sum[cyz];
         return r;
      end
      den = (bkg_scale == 0) ? 64'd1 : 64'(bkg_scale);
      sb = (64'(it.background_count) * tgt_scale * 256) / den;
      root = isqrt(64'(it.background_count) << 16);
      err = (root * tgt_scale) / den;
      d = longint'(64'(it.target_count) * 256) - longint'(sb);
      thr = longint'(64'(sigma) * err);
      if (d > 64'sd549755813887) r.difference = 40'h7F_FFFF_FFFF;
      else if (d < -64'sd549755813888) r.difference = 40'h80_0000_0000;
      else r.difference = d[DIFF_W-1:0];
      if (d > thr && sb > 0) begin
         if (err == 0) sig = 64'hFFFF_FFFF;
         else begin
            sig = (64'(d) << 8) / err;
            if (sig > 64'hFFFF_FFFF) sig = 64'hFFFF_FFFF;
         end
         r.class_code = CLASS_EXCESS;
         r.significance = sig[SIG_W-1:0];
         xy_sum[cxy] = sat40(xy_sum[cxy], r.significance);
         xz_sum[cxz] = sat40(xz_sum[cxz], r.significance);
         yz_sum[cyz] = sat40(yz_sum[cyz], r.significance);
      end else if (-d > thr) begin
         r.class_code = CLASS_DEFICIT;
      end
      return r;
   endfunction

   // driver: hold payload until accepted
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(voxel_result(req_item));
            void'(pending_items.pop_front());
         end
         if ((!req_valid || !req_stall) && !(req_valid && !req_stall && 0)) begin
            if (req_valid && !req_stall) begin
               if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
                  req_valid <= 1'b1;
                  req_item <= pending_items[0];
               end else begin
                  req_valid <= 1'b0;
               end
            end else if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_item <= pending_items[0];
            end
         end
      end
   end

   // monitor and receiver stall
   always @(posedge clock) begin
      if (!reset) begin
         rsp_stall <= ($urandom_range(99) < idle_pct);
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", rsp_item);
            end else begin
               rsp_item_type e;
               e = expected_rsps.pop_front();
               if (e !== rsp_item) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: expected %p actual %p", e, rsp_item);
               end
            end
         end
      end
   end

   // watchdog: cycles with no accepted item on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic req_item_type rand_item(bit force_read);
      req_item_type it;
      logic [COUNT_BITS-1:0] b;
      it.req_type = force_read ? 1'b1 : ($urandom_range(99) < 25);
      // each bin is drawn from 0 to 3 half the time so reads see nonzero sums
      it.bin_x = ($urandom_range(1)) ? 5'($urandom_range(3)) : 5'($urandom);
      it.bin_y = ($urandom_range(1)) ? 5'($urandom_range(3)) : 5'($urandom);
      it.bin_z = ($urandom_range(1)) ? 5'($urandom_range(3)) : 5'($urandom);
      case ($urandom_range(3))
         0: b = COUNT_BITS'($urandom);
         1: b = COUNT_BITS'($urandom_range(1000));
         2: b = COUNT_BITS'($urandom_range(20));
         default: b = COUNT_BITS'($urandom_range(200000));
      endcase
      it.background_count = b;
      case ($urandom_range(3))
         0: it.target_count = COUNT_BITS'($urandom);
         1: it.target_count = b + COUNT_BITS'($urandom_range(300));
         2: it.target_count = (b > 300) ? b - COUNT_BITS'($urandom_range(300)) : '0;
         default: it.target_count = b;
      endcase
      return it;
   endfunction

   // write one register while the block is idle
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_TARGET_SCALE: tgt_scale = val;
         CSR_BACKGROUND_SCALE: bkg_scale = val;
         default: sigma = val[SIGMA_W-1:0];
      endcase
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || expected_rsps.size() > 0 || req_valid)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic add(bit rd, int x, int y, int z, int t, int b);
      req_item_type it;
      it.req_type = rd;
      it.bin_x = BIN_W'(x);
      it.bin_y = BIN_W'(y);
      it.bin_z = BIN_W'(z);
      it.target_count = COUNT_BITS'(t);
      it.background_count = COUNT_BITS'(b);
      pending_items.push_back(it);
   endtask

   initial begin
      req_item_type q;
      tgt_scale = TARGET_SCALE_RST;
      bkg_scale = BACKGROUND_SCALE_RST;
      sigma = SIGMA_RST;
      for (int i = 0; i < CELLS; i++) begin
         xy_sum[i] = '0;
         xz_sum[i] = '0;
         yz_sum[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: count extremes, zero background, deficit, corners, reads
      add(0, 0, 0, 0, 0, 0);
      add(0, 31, 31, 31, 24'hFFFFFF, 24'hFFFFFF);
      add(0, 31, 31, 31, 24'hFFFFFF, 1);
      add(0, 0, 0, 0, 24'hFFFFFF, 0);
      add(0, 1, 2, 3, 0, 24'hFFFFFF);
      add(0, 1, 2, 3, 5000, 100);
      add(0, 1, 2, 3, 100, 100);
      add(1, 1, 2, 3, 0, 0);
      add(1, 31, 31, 31, 24'hFFFFFF, 24'hFFFFFF);
      add(1, 5, 6, 7, 0, 0);
      drain();

      // huge target scale, tiny background scale: saturation, zero threshold
      write_reg(CSR_TARGET_SCALE, 20'hFFFFF);
      write_reg(CSR_BACKGROUND_SCALE, 20'd1);
      write_reg(CSR_SIGMA_THRESHOLD, 20'd0);
      add(0, 2, 2, 2, 24'hFFFFFF, 1);
      add(0, 2, 2, 2, 0, 24'hFFFFFF);
      add(0, 2, 2, 2, 24'hFFFFFF, 24'hFFFFFF);
      for (int i = 0; i < 40; i++) add(0, 9, 9, 9, 24'hFFFFFF, 1);
      add(1, 9, 9, 9, 0, 0);
      drain();
      // tiny target scale over zero background scale (treated as one)
      write_reg(CSR_TARGET_SCALE, 20'd1);
      write_reg(CSR_BACKGROUND_SCALE, 20'd0);
      write_reg(CSR_SIGMA_THRESHOLD, 20'd15);
      add(0, 3, 3, 3, 5, 1);
      add(0, 3, 3, 3, 0, 24'hFFFFFF);
      add(1, 3, 3, 3, 0, 0);
      drain();

      // random phases across settings; phase 1 has no idling
      for (int ph = 0; ph < 8; ph++) begin
         idle_pct = (ph == 1) ? 0 : 35;
         write_reg(CSR_TARGET_SCALE, (ph == 0) ? 20'd10000 : 20'($urandom_range(1, 20'hFFFFF)));
         write_reg(CSR_BACKGROUND_SCALE,
                   (ph == 0) ? 20'd10000 : 20'($urandom_range(1, 20'hFFFFF)));
         write_reg(CSR_SIGMA_THRESHOLD, CSR_DATA_W'($urandom_range(15)));
         for (int i = 0; i < 200; i++) begin
            q = rand_item(0);
            pending_items.push_back(q);
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
